// ----- hdl/scm_pkg.sv -----
// Shared types, constants and keyword tables of the serial command line monitor.
package scm_pkg;

   // Longest line is MAX_LINE-1 characters
   localparam int MAX_LINE   = 32;
   localparam int LINE_LEN_W = $clog2(MAX_LINE);

   // Configuration registers
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_READY_PERIOD   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_PERIOD = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  READY_PERIOD_RST   = 16'd1000;
   localparam logic [CSR_DATA_W-1:0]  TRIGGER_PERIOD_RST = 16'd2000;

   // Byte codes
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Response codes
   typedef enum logic [2:0] {
      RESP_READY    = 3'd0,
      RESP_AUTO     = 3'd1,
      RESP_PONG     = 3'd2,
      RESP_HELP     = 3'd3,
      RESP_TRIG_OK  = 3'd4,
      RESP_UNKNOWN  = 3'd5,
      RESP_TOO_LONG = 3'd6
   } resp_code_type;

   // Keywords: PING, HELP, TRIGGER
   localparam int NUM_KW = 3;
   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{8'h50, 8'h49, 8'h4e, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h48, 8'h45, 8'h4c, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h54, 8'h52, 8'h49, 8'h47, 8'h47, 8'h45, 8'h52, 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd4, 3'd7};
   localparam resp_code_type KW_CODE [NUM_KW] = '{RESP_PONG, RESP_HELP, RESP_TRIG_OK};

   // Result slots of one request, in delivery order (lowest bit first)
   localparam int SLOT_STARTUP = 0;
   localparam int SLOT_CMD     = 1;
   localparam int SLOT_BEACON  = 2;
   localparam int SLOT_AUTO    = 3;
   localparam int NUM_SLOTS    = 4;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      resp_code_type        cmd_code;
   } bundle_type;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hdl/scm_req_if.sv -----
// Request channel: one tick with an optional received byte.
interface scm_req_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] rx_byte;

   modport source (output valid, output byte_valid, output rx_byte, input ready);
   modport sink   (input valid, input byte_valid, input rx_byte, output ready);
endinterface

// ----- hdl/scm_rsp_if.sv -----
// Response channel: one response code with trigger and end-of-tick flags.
interface scm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] response_code;
   logic       fire_trigger;
   logic       last_of_tick;

   modport source (output valid, output response_code, output fire_trigger,
                   output last_of_tick, input ready);
   modport sink   (input valid, input response_code, input fire_trigger,
                   input last_of_tick, output ready);
endinterface

// ----- hdl/serial_command_line_monitor_top.sv -----
// Top level of the serial command line monitor.
//
// Each request is one millisecond tick with an optional received byte; the block
// folds letters to upper case, tracks a running match of the line against PING,
// HELP and TRIGGER, and keeps the ready-beacon and auto-trigger tick counters.
// A request is taken, back to back, whenever the four-entry result queue has room;
// it yields zero to four responses (start-up ready, command response, ready
// beacon, auto trigger), which leave one per cycle through a registered response
// port unless it stalls, the last one flagged. Sustained throughput is one request
// per cycle while requests average at most one response, and is set by that single
// response port otherwise. No clearing pass follows reset. The user must write
// period registers via the csr_ port while no request is pending; block does not check.
module serial_command_line_monitor_top (
   input  logic                                clock,
   input  logic                                reset,
   scm_req_if.sink                             req_chan,
   scm_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [scm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [scm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   scm_pkg::queue_status_type  q_status;
   scm_pkg::bundle_type        q_push_data;
   scm_pkg::bundle_type        q_pop_data;
   logic                       q_push;
   logic                       q_pop;

   scm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_push_data  (q_push_data)
   );

   scm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   scm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop_data (q_pop_data),
      .q_pop      (q_pop),
      .rsp        (rsp_chan)
   );

endmodule

// ----- hdl/scm_front.sv -----
// Front end: accepts requests, runs line parsing and tick counters, builds result bundles.
module scm_front (
   input  logic                                clock,
   input  logic                                reset,
   scm_req_if.sink                             req,
   input  logic                                csr_write_en,
   input  logic [scm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [scm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  scm_pkg::queue_status_type           q_status,
   output logic                                q_push,
   output scm_pkg::bundle_type                 q_push_data
);

   localparam logic [scm_pkg::LINE_LEN_W-1:0] LINE_LAST =
      scm_pkg::LINE_LEN_W'(scm_pkg::MAX_LINE - 1);

   logic [scm_pkg::CSR_DATA_W-1:0]   ready_period_ff, ready_period_in;
   logic [scm_pkg::CSR_DATA_W-1:0]   trigger_period_ff, trigger_period_in;
   logic [scm_pkg::LINE_LEN_W-1:0]   line_len_ff, line_len_in;
   logic [scm_pkg::NUM_KW-1:0]       kw_flags_ff, kw_flags_in;
   logic [scm_pkg::CSR_DATA_W-1:0]   ready_cnt_ff, ready_cnt_in;
   logic [scm_pkg::CSR_DATA_W-1:0]   trigger_cnt_ff, trigger_cnt_in;
   logic                             started_ff, started_in;

   logic                             accept;
   logic                             is_term;
   logic                             overflow;
   logic [7:0]                       char_up;
   logic [scm_pkg::NUM_KW-1:0]       kw_keep;
   logic                             ready_hit;
   logic                             trigger_hit;
   logic                             cmd_fire;
   scm_pkg::resp_code_type           cmd_code;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   // Byte classification and case folding
   assign is_term  = (req.rx_byte == scm_pkg::CHAR_CR) || (req.rx_byte == scm_pkg::CHAR_LF);
   assign overflow = (line_len_ff >= LINE_LAST);
   assign char_up  = ((req.rx_byte >= scm_pkg::CHAR_LOWER_A) &&
                      (req.rx_byte <= scm_pkg::CHAR_LOWER_Z)) ?
                     (req.rx_byte - scm_pkg::CASE_OFFSET) : req.rx_byte;

   // Running keyword match at the current position
   always_comb begin
      for (int k = 0; k < scm_pkg::NUM_KW; k++) begin
         kw_keep[k] = (line_len_ff < scm_pkg::LINE_LEN_W'(scm_pkg::KW_LEN[k])) &&
                      (scm_pkg::KW_TEXT[k][line_len_ff[2:0]] == char_up);
      end
   end

   // Command decode on a terminator, first matching keyword wins
   always_comb begin
      cmd_code = scm_pkg::RESP_UNKNOWN;
      for (int k = scm_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (kw_flags_ff[k] && (line_len_ff == scm_pkg::LINE_LEN_W'(scm_pkg::KW_LEN[k]))) begin
            cmd_code = scm_pkg::KW_CODE[k];
         end
      end
   end

   assign ready_hit   = (ready_cnt_ff >= ready_period_ff);
   assign trigger_hit = (trigger_cnt_ff >= trigger_period_ff);

   // Next state and result bundle
   always_comb begin
      line_len_in    = line_len_ff;
      kw_flags_in    = kw_flags_ff;
      ready_cnt_in   = ready_cnt_ff;
      trigger_cnt_in = trigger_cnt_ff;
      started_in     = started_ff;
      cmd_fire       = 1'b0;
      q_push_data.cmd_code = cmd_code;
      if (accept) begin
         started_in = 1'b1;
         if (req.byte_valid) begin
            priority if (is_term) begin
               if (line_len_ff != '0) begin
                  cmd_fire    = 1'b1;
                  line_len_in = '0;
                  kw_flags_in = '1;
               end
            end else if (!overflow) begin
               line_len_in = line_len_ff + 1'b1;
               kw_flags_in = kw_flags_ff & kw_keep;
            end else begin
               cmd_fire    = 1'b1;
               q_push_data.cmd_code = scm_pkg::RESP_TOO_LONG;
               line_len_in = '0;
               kw_flags_in = '1;
            end
         end
         ready_cnt_in   = ready_hit ? '0 : ready_cnt_ff + 1'b1;
         trigger_cnt_in = trigger_hit ? '0 : trigger_cnt_ff + 1'b1;
      end
      q_push_data.mask[scm_pkg::SLOT_STARTUP] = !started_ff;
      q_push_data.mask[scm_pkg::SLOT_CMD]     = cmd_fire;
      q_push_data.mask[scm_pkg::SLOT_BEACON]  = ready_hit;
      q_push_data.mask[scm_pkg::SLOT_AUTO]    = trigger_hit;
   end

   assign q_push = accept && (q_push_data.mask != '0);

   // Configuration writes
   always_comb begin
      ready_period_in   = ready_period_ff;
      trigger_period_in = trigger_period_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            scm_pkg::CSR_READY_PERIOD:   ready_period_in   = csr_wdata;
            scm_pkg::CSR_TRIGGER_PERIOD: trigger_period_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_period_ff   <= scm_pkg::READY_PERIOD_RST;
         trigger_period_ff <= scm_pkg::TRIGGER_PERIOD_RST;
         line_len_ff       <= '0;
         kw_flags_ff       <= '1;
         ready_cnt_ff      <= '0;
         trigger_cnt_ff    <= '0;
         started_ff        <= 1'b0;
      end else begin
         ready_period_ff   <= ready_period_in;
         trigger_period_ff <= trigger_period_in;
         line_len_ff       <= line_len_in;
         kw_flags_ff       <= kw_flags_in;
         ready_cnt_ff      <= ready_cnt_in;
         trigger_cnt_ff    <= trigger_cnt_in;
         started_ff        <= started_in;
      end
   end

`ifndef ASSERT_OFF
   // Any accepted request leaves the start-up ready behind
   a_started_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> started_ff)
      else $error("start-up flag not set after accepted request");
`endif

endmodule

// ----- hdl/scm_queue.sv -----
// Short queue of result bundles between the front and back ends.
module scm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  scm_pkg::bundle_type         push_data,
   input  logic                        pop,
   output scm_pkg::bundle_type         pop_data,
   output scm_pkg::queue_status_type   status
);

   scm_pkg::bundle_type                 entry_ff [scm_pkg::QUEUE_DEPTH];
   logic [scm_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [scm_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [scm_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   function automatic logic [scm_pkg::QUEUE_CNT_W-1:0] QUEUE_CNT_W_one(input logic b);
      return {{(scm_pkg::QUEUE_CNT_W-1){1'b0}}, b};
   endfunction

   assign status.full  = (count_ff == scm_pkg::QUEUE_CNT_W'(scm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W_one(push) - QUEUE_CNT_W_one(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("bundle pushed into full queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("bundle popped from empty queue");
`endif

endmodule

// ----- hdl/scm_back.sv -----
// Back end: walks each result bundle and delivers one response per cycle unless stalled.
module scm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  scm_pkg::queue_status_type   q_status,
   input  scm_pkg::bundle_type         q_pop_data,
   output logic                        q_pop,
   scm_rsp_if.source                   rsp
);

   logic [scm_pkg::NUM_SLOTS-1:0]  pend_ff, pend_in;
   scm_pkg::resp_code_type         cmd_code_ff, cmd_code_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   scm_pkg::resp_code_type         rsp_code_ff, rsp_code_in;
   logic                           rsp_fire_ff, rsp_fire_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [scm_pkg::NUM_SLOTS-1:0]  sel;
   logic [scm_pkg::NUM_SLOTS-1:0]  pend_rest;
   logic [scm_pkg::NUM_SLOTS-1:0]  pend_after;
   logic                           load;
   scm_pkg::resp_code_type         sel_code;

   // Lowest pending slot goes first
   assign sel       = pend_ff & (~pend_ff + 1'b1);
   assign pend_rest = pend_ff & ~sel;
   assign load      = (pend_ff != '0) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      priority if (sel[scm_pkg::SLOT_STARTUP]) begin
         sel_code = scm_pkg::RESP_READY;
      end else if (sel[scm_pkg::SLOT_CMD]) begin
         sel_code = cmd_code_ff;
      end else if (sel[scm_pkg::SLOT_BEACON]) begin
         sel_code = scm_pkg::RESP_READY;
      end else begin
         sel_code = scm_pkg::RESP_AUTO;
      end
   end

   // Bundle walk and refill from the queue
   always_comb begin
      pend_after  = load ? pend_rest : pend_ff;
      q_pop       = (pend_after == '0) && !q_status.empty;
      pend_in     = q_pop ? q_pop_data.mask : pend_after;
      cmd_code_in = q_pop ? q_pop_data.cmd_code : cmd_code_ff;
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_fire_in  = rsp_fire_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = sel_code;
         rsp_fire_in  = (sel_code == scm_pkg::RESP_AUTO) || (sel_code == scm_pkg::RESP_TRIG_OK);
         rsp_last_in  = (pend_rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_code_ff <= cmd_code_in;
      rsp_code_ff <= rsp_code_in;
      rsp_fire_ff <= rsp_fire_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.response_code = rsp_code_ff;
   assign rsp.fire_trigger  = rsp_fire_ff;
   assign rsp.last_of_tick  = rsp_last_ff;

`ifndef ASSERT_OFF
   // A request's results leave without a gap until its last one
   a_no_gap_in_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_of_tick) |=> rsp.valid)
      else $error("gap inside the results of one request");
`endif

endmodule
